// File: hdl/prefix_code_bit_packer_macros.svh
// Assertion macros for the prefix code bit packer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PREFIX_CODE_BIT_PACKER_MACROS_SVH
`define PREFIX_CODE_BIT_PACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCBP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pcbp_pkg.sv
// Shared types and constants of the prefix code bit packer.
// No dependencies.
package pcbp_pkg;

  localparam int BYTE_BITS         = 8;
  localparam int DEF_MAX_CODE_BITS = 32;
  localparam int DEF_SYMBOL_COUNT  = 256;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP,
    ST_FLUSH
  } state_e;

  // Status of one merge step of the shift unit.
  typedef struct packed {
    logic full;  // byte completes in this step
    logic last;  // no further byte can follow from this codeword
    logic done;  // codeword fully consumed
  } step_stat_t;

endpackage

// File: hdl/pcbp_step.sv
// Shift-and-merge unit: moves up to one byte's worth of codeword bits into
// the partial byte per use. Depends on pcbp_pkg.
module pcbp_step #(
  parameter int CODE_W = 32,
  parameter int LEN_W  = 6
) (
  input  logic [7:0]        partial_i,
  input  logic [2:0]        fill_i,
  input  logic [CODE_W-1:0] cw_i,      // pending codeword bits, left aligned
  input  logic [LEN_W-1:0]  rem_i,     // pending codeword bit count
  output logic [7:0]        merged_o,
  output logic [7:0]        partial_o,
  output logic [2:0]        fill_o,
  output logic [CODE_W-1:0] cw_o,
  output logic [LEN_W-1:0]  rem_o,
  output pcbp_pkg::step_stat_t stat_o
);
  import pcbp_pkg::*;

  logic [3:0] room;
  logic [3:0] take;
  logic [7:0] kept;
  logic [3:0] fill_sum;

  always_comb begin
    room = 4'(BYTE_BITS) - {1'b0, fill_i};
    take = (rem_i < LEN_W'(room)) ? rem_i[3:0] : room;
    // keep the top take bits of the codeword window
    kept = cw_i[CODE_W-1 -: 8] & ~(8'hFF >> take);
    merged_o = partial_i | (kept >> fill_i);
    fill_sum = {1'b0, fill_i} + take;
    cw_o = cw_i << take;
    rem_o = rem_i - LEN_W'(take);
    stat_o.full = fill_sum[3];
    stat_o.done = (rem_o == '0);
    stat_o.last = (rem_o < LEN_W'(BYTE_BITS));
    fill_o = fill_sum[2:0];
    partial_o = fill_sum[3] ? 8'h00 : merged_o;
  end

endmodule

// File: hdl/prefix_code_bit_packer.sv
// Top level of the table-driven prefix code bit packer.
// Depends on pcbp_pkg, pcbp_step and prefix_code_bit_packer_macros.svh.
//
//   channel   dir  handshake                    contents
//   s_axis    in   s_axis_tvalid/s_axis_tready  mode, symbol, codeword, length
//   m_axis    out  m_axis_tvalid/m_axis_tready  packed byte, bit count, last
//
// A load item writes a table entry. An encode item makes one table read,
// one fetch, then one pass of the shared shift unit per step, at most five
// for a 32-bit codeword (one byte or partial byte per step). A flush item
// with bits pending emits the partial byte. Input is taken only while the
// sequencer idles; a step that completes a byte holds while the output
// register is full and not taken. Reset clears the accumulator; the code
// table is not cleared and needs loading before use.
`include "prefix_code_bit_packer_macros.svh"

module prefix_code_bit_packer #(
  parameter int MAX_CODE_BITS = pcbp_pkg::DEF_MAX_CODE_BITS,
  parameter int SYMBOL_COUNT  = pcbp_pkg::DEF_SYMBOL_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // symbol[7:0], code_value[39:8],
                                      // code_length[45:40], zero[47:46]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // byte_out[7:0], valid_bits[11:8],
                                      // zero[15:12]
  output logic        m_axis_tlast    // last
);
  import pcbp_pkg::*;

  localparam int LEN_CAP = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
  localparam int CODE_W  = LEN_CAP;
  localparam int LEN_W   = $clog2(LEN_CAP + 1);
  localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ENTRY_W = CODE_W + LEN_W;

  // code table: left-aligned codeword over its length
  logic [ENTRY_W-1:0] mem_q [SYMBOL_COUNT];
  logic [ENTRY_W-1:0] rd_data_q;

  state_e state_q, state_d;
  logic [7:0]        partial_q, partial_d;
  logic [2:0]        fill_q, fill_d;
  logic [CODE_W-1:0] cw_q, cw_d;
  logic [LEN_W-1:0]  rem_q, rem_d;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic [3:0] out_vbits_q;
  logic       out_last_q;

  logic       in_acc;
  mode_e      in_mode;
  logic [7:0] in_sym;
  logic       sym_ok;
  logic [LEN_W-1:0]  cap_len;
  logic [LEN_W-1:0]  shamt;
  logic [CODE_W-1:0] aligned;

  logic       mem_wr, mem_rd;
  logic       out_free, emit, emit_last;
  logic [7:0] emit_byte;
  logic [3:0] emit_vbits;

  logic [7:0]        st_merged, st_partial;
  logic [2:0]        st_fill;
  logic [CODE_W-1:0] st_cw;
  logic [LEN_W-1:0]  st_rem;
  step_stat_t        st_stat;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_mode = mode_e'(s_axis_tuser);
  assign in_sym  = s_axis_tdata[7:0];
  assign sym_ok  = ({1'b0, in_sym} < 9'(SYMBOL_COUNT));

  // saturate the length and drop codeword bits above it
  assign cap_len = ({1'b0, s_axis_tdata[45:40]} > 7'(LEN_CAP)) ?
                   LEN_W'(LEN_CAP) : LEN_W'(s_axis_tdata[45:40]);
  assign shamt   = LEN_W'(CODE_W) - cap_len;
  assign aligned = s_axis_tdata[8 +: CODE_W] << shamt;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  pcbp_step #(
    .CODE_W (CODE_W),
    .LEN_W  (LEN_W)
  ) u_step (
    .partial_i (partial_q),
    .fill_i    (fill_q),
    .cw_i      (cw_q),
    .rem_i     (rem_q),
    .merged_o  (st_merged),
    .partial_o (st_partial),
    .fill_o    (st_fill),
    .cw_o      (st_cw),
    .rem_o     (st_rem),
    .stat_o    (st_stat)
  );

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[in_sym[ADDR_W-1:0]] <= {aligned, cap_len};
    end
    if (mem_rd) begin
      rd_data_q <= mem_q[in_sym[ADDR_W-1:0]];
    end
  end

  always_comb begin
    state_d    = state_q;
    partial_d  = partial_q;
    fill_d     = fill_q;
    cw_d       = cw_q;
    rem_d      = rem_q;
    mem_wr     = 1'b0;
    mem_rd     = 1'b0;
    emit       = 1'b0;
    emit_byte  = st_merged;
    emit_vbits = 4'(BYTE_BITS);
    emit_last  = st_stat.last;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            MODE_LOAD: begin
              mem_wr = sym_ok;
            end
            MODE_ENCODE: begin
              if (sym_ok) begin
                mem_rd  = 1'b1;
                state_d = ST_FETCH;
              end
            end
            MODE_FLUSH: begin
              if (fill_q != 3'd0) begin
                state_d = ST_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        cw_d    = rd_data_q[ENTRY_W-1:LEN_W];
        rem_d   = rd_data_q[LEN_W-1:0];
        state_d = ST_STEP;
      end
      ST_STEP: begin
        // hold a completing step until the output register can take it
        if (!st_stat.full || out_free) begin
          partial_d = st_partial;
          fill_d    = st_fill;
          cw_d      = st_cw;
          rem_d     = st_rem;
          emit      = st_stat.full;
          if (st_stat.done) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = partial_q;
          emit_vbits = {1'b0, fill_q};
          emit_last  = 1'b1;
          partial_d  = 8'h00;
          fill_d     = 3'd0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      partial_q <= 8'h00;
      fill_q    <= 3'd0;
      rem_q     <= '0;
    end else begin
      state_q   <= state_d;
      partial_q <= partial_d;
      fill_q    <= fill_d;
      rem_q     <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q <= cw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= emit_byte;
      out_vbits_q <= emit_vbits;
      out_last_q  <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'h0, out_vbits_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;

  `PCBP_ASSERT_IMPL(a_idle_no_pending, state_q == ST_IDLE, rem_q == '0,
    "codeword bits left over when sequencer went idle")
  `PCBP_ASSERT_IMPL(a_flush_nonempty, state_q == ST_FLUSH, fill_q != 3'd0,
    "flush state entered with empty accumulator")
  `PCBP_ASSERT_IMPL(a_partial_is_last,
    out_valid_q && (out_vbits_q != 4'(BYTE_BITS)), out_last_q,
    "partial byte not marked last")
  `PCBP_ASSERT_IMPL(a_emit_free_slot, emit && out_valid_q, m_axis_tready,
    "byte emitted over an untaken output")
  `PCBP_ASSERT_NEXT(a_flush_clears, state_q == ST_FLUSH && emit,
    fill_q == 3'd0 && partial_q == 8'h00,
    "accumulator not cleared after flush")

endmodule
